@@ sv/bitmap_free_run_finder_defines.svh @@
`ifndef BITMAP_FREE_RUN_FINDER_DEFINES_SVH
`define BITMAP_FREE_RUN_FINDER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BFRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define BFRF_ASSERT_NEVER(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("forbidden condition seen");
`else
`define BFRF_ASSERT(lbl, prop)
`define BFRF_ASSERT_NEVER(lbl, prop)
`endif

`endif

@@ sv/bfrf_pkg.sv @@
package bfrf_pkg;

  localparam int unsigned GroupBits = 32768;
  localparam int unsigned IdxW      = 20;
  localparam int unsigned CfgAddrW  = 4;
  localparam int unsigned MidDepth  = 2;
  localparam int unsigned OutDepth  = 2;

  typedef enum logic [1:0] {
    RegRunWanted,
    RegFirstUsable,
    RegItabLen,
    RegBitsInGroup
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  map_byte;
    logic [31:0] group_base_block;
    logic [31:0] block_map_location;
    logic [31:0] inode_map_location;
    logic [31:0] inode_table_location;
    logic        group_first;
    logic        group_last;
  } map_req_t;

  typedef struct packed {
    logic        run_found;
    logic [31:0] run_first_block;
    logic [15:0] run_length_out;
    logic [15:0] still_wanted;
  } run_rsp_t;

  typedef struct packed {
    logic [15:0] run_wanted;
    logic [31:0] first_usable_block;
    logic [15:0] inode_table_length;
    logic [15:0] bits_in_group;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      free;
    logic [IdxW-1:0] pos;
    logic [31:0]     base;
    logic            first;
    logic            last;
  } slot_t;

endpackage

@@ sv/bfrf_fifo.sv @@
`include "bitmap_free_run_finder_defines.svh"

module bfrf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `BFRF_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH))
  `BFRF_ASSERT(a_cnt_grow, do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ sv/bfrf_front.sv @@
module bfrf_front #(
  parameter int unsigned GROUP_BITS = bfrf_pkg::GroupBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfrf_pkg::map_req_t req_i,
  input  logic              accept_i,
  input  bfrf_pkg::cfg_t    cfg_i,
  output bfrf_pkg::slot_t   slot_o
);

  localparam int unsigned PosW = $clog2(GROUP_BITS) + 2;

  logic [PosW-1:0] pos_q, pos_d, base_pos, step_pos;
  logic [7:0]      free;

  assign base_pos = req_i.group_first ? '0 : pos_q;
  assign step_pos = base_pos + PosW'(8);

  always_comb begin
    logic [33:0] idx;
    logic [33:0] blk;
    logic [33:0] itab_end;
    logic        excl;
    itab_end = {2'b0, req_i.inode_table_location} + {18'b0, cfg_i.inode_table_length};
    for (int k = 0; k < 8; k++) begin
      idx  = 34'(base_pos) + 34'(k);
      blk  = {2'b0, req_i.group_base_block} + idx;
      excl = (idx >= 34'(GROUP_BITS)) || (idx >= {18'b0, cfg_i.bits_in_group})
          || (blk[33:32] != 2'b0) || (blk == '0)
          || (blk == {2'b0, req_i.block_map_location})
          || (blk == {2'b0, req_i.inode_map_location})
          || ((blk >= {2'b0, req_i.inode_table_location}) && (blk < itab_end))
          || (blk < {2'b0, cfg_i.first_usable_block});
      free[k] = !excl && !req_i.map_byte[k];
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (accept_i) begin
      if (req_i.group_last) begin
        pos_d = '0;
      end else if (step_pos >= PosW'(GROUP_BITS)) begin
        pos_d = PosW'(GROUP_BITS);
      end else begin
        pos_d = step_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  assign slot_o.free  = free;
  assign slot_o.pos   = bfrf_pkg::IdxW'(base_pos);
  assign slot_o.base  = req_i.group_base_block;
  assign slot_o.first = req_i.group_first;
  assign slot_o.last  = req_i.group_last;

endmodule

@@ sv/bfrf_back.sv @@
`include "bitmap_free_run_finder_defines.svh"

module bfrf_back #(
  parameter int unsigned GROUP_BITS = bfrf_pkg::GroupBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfrf_pkg::slot_t   slot_i,
  input  logic              slot_empty_i,
  output logic              slot_pop_o,
  input  logic [15:0]       run_wanted_i,
  input  logic              res_full_i,
  output logic              res_push_o,
  output bfrf_pkg::run_rsp_t res_o
);

  localparam int unsigned StartW = $clog2(GROUP_BITS);

  logic [15:0]       cur_len_q, cur_len_d, top_len_q, top_len_d;
  logic [StartW-1:0] cur_start_q, cur_start_d, top_start_q, top_start_d;
  logic              stop_q, stop_d;

  assign slot_pop_o = !slot_empty_i && (!slot_i.last || !res_full_i);
  assign res_push_o = slot_pop_o && slot_i.last;

  always_comb begin
    logic [bfrf_pkg::IdxW-1:0] idx;
    cur_len_d   = cur_len_q;
    cur_start_d = cur_start_q;
    top_len_d   = top_len_q;
    top_start_d = top_start_q;
    stop_d      = stop_q;
    if (slot_i.first) begin
      cur_len_d   = '0;
      cur_start_d = '0;
      top_len_d   = '0;
      top_start_d = '0;
      stop_d      = 1'b0;
    end
    for (int k = 0; k < 8; k++) begin
      idx = slot_i.pos + bfrf_pkg::IdxW'(k);
      if (!stop_d) begin
        if (!slot_i.free[k]) begin
          cur_len_d = '0;
        end else begin
          if (cur_len_d == '0) begin
            cur_start_d = idx[StartW-1:0];
          end
          if (cur_len_d == run_wanted_i) begin
            stop_d = 1'b1;
          end else begin
            cur_len_d = cur_len_d + 1'b1;
            if (cur_len_d > top_len_d) begin
              top_len_d   = cur_len_d;
              top_start_d = cur_start_d;
            end
          end
        end
      end
    end
  end

  always_comb begin
    res_o.run_found       = (top_len_d != '0);
    res_o.run_first_block = res_o.run_found
                          ? slot_i.base + 32'(top_start_d) : '0;
    res_o.run_length_out  = top_len_d;
    res_o.still_wanted    = run_wanted_i - top_len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q   <= '0;
      cur_start_q <= '0;
      top_len_q   <= '0;
      top_start_q <= '0;
      stop_q      <= 1'b0;
    end else if (slot_pop_o) begin
      if (slot_i.last) begin
        cur_len_q   <= '0;
        cur_start_q <= '0;
        top_len_q   <= '0;
        top_start_q <= '0;
        stop_q      <= 1'b0;
      end else begin
        cur_len_q   <= cur_len_d;
        cur_start_q <= cur_start_d;
        top_len_q   <= top_len_d;
        top_start_q <= top_start_d;
        stop_q      <= stop_d;
      end
    end
  end

  `BFRF_ASSERT_NEVER(a_no_drop, res_push_o && res_full_i)
  `BFRF_ASSERT(a_clear_after_last, slot_pop_o && slot_i.last |=> top_len_q == '0 && !stop_q)

endmodule

@@ sv/bitmap_free_run_finder.sv @@
// Bitmap free-run finder. Bitmap bytes of one block group are pushed one per cycle
// while full is low; each request is classified in the cycle it is taken and
// queued, and the run tracker consumes one queued byte per cycle, eight bits at a
// time, unless the result queue is full when a group's last byte is due. The last
// byte is held in the request queue and its result is registered in the result
// queue. Each side holds two entries, so either side can stall alone.
// Registers (byte address): run_wanted 0x0, first_usable_block 0x4,
// inode_table_length 0x8, bits_in_group 0xc; write them only while idle.
module bitmap_free_run_finder #(
  parameter int unsigned GROUP_BITS = bfrf_pkg::GroupBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  bfrf_pkg::map_req_t                 map_req_i,
  output logic                               empty,
  input  logic                               pop,
  output bfrf_pkg::run_rsp_t                 run_rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bfrf_pkg::CfgAddrW-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  bfrf_pkg::cfg_t     cfg_q;
  bfrf_pkg::slot_t    slot_in, slot_out;
  bfrf_pkg::run_rsp_t res;
  bfrf_pkg::reg_idx_e reg_idx;
  logic               accept, slot_empty, slot_pop, res_full, res_push, cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = bfrf_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;
  assign accept  = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_wanted         <= 16'd1;
      cfg_q.first_usable_block <= '0;
      cfg_q.inode_table_length <= '0;
      cfg_q.bits_in_group      <= 16'd32768;
    end else if (cfg_we) begin
      unique case (reg_idx)
        bfrf_pkg::RegRunWanted:   cfg_q.run_wanted         <= pwdata[15:0];
        bfrf_pkg::RegFirstUsable: cfg_q.first_usable_block <= pwdata;
        bfrf_pkg::RegItabLen:     cfg_q.inode_table_length <= pwdata[15:0];
        bfrf_pkg::RegBitsInGroup: cfg_q.bits_in_group      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bfrf_pkg::RegRunWanted:   prdata = {16'b0, cfg_q.run_wanted};
      bfrf_pkg::RegFirstUsable: prdata = cfg_q.first_usable_block;
      bfrf_pkg::RegItabLen:     prdata = {16'b0, cfg_q.inode_table_length};
      bfrf_pkg::RegBitsInGroup: prdata = {16'b0, cfg_q.bits_in_group};
      default:                  prdata = '0;
    endcase
  end

  bfrf_front #(.GROUP_BITS(GROUP_BITS)) u_front (
    .clk_i,
    .rst_ni,
    .req_i    (map_req_i),
    .accept_i (accept),
    .cfg_i    (cfg_q),
    .slot_o   (slot_in)
  );

  bfrf_fifo #(
    .WIDTH ($bits(bfrf_pkg::slot_t)),
    .DEPTH (bfrf_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (slot_in),
    .full_o  (full),
    .pop_i   (slot_pop),
    .data_o  (slot_out),
    .empty_o (slot_empty)
  );

  bfrf_back #(.GROUP_BITS(GROUP_BITS)) u_back (
    .clk_i,
    .rst_ni,
    .slot_i       (slot_out),
    .slot_empty_i (slot_empty),
    .slot_pop_o   (slot_pop),
    .run_wanted_i (cfg_q.run_wanted),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  bfrf_fifo #(
    .WIDTH ($bits(bfrf_pkg::run_rsp_t)),
    .DEPTH (bfrf_pkg::OutDepth)
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (run_rsp_o),
    .empty_o (empty)
  );

endmodule
